// ===== rtl/ray_rotate_translate_unit_defines.svh =====
// assertion macros for the ray rotate and translate unit
`ifndef RAY_ROTATE_TRANSLATE_UNIT_DEFINES_SVH
`define RAY_ROTATE_TRANSLATE_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define RRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrt_pkg.sv =====
`timescale 1ns / 1ps
// types, constants, sine table and arithmetic helpers for the ray rotate and translate unit
package rrt_pkg;

   // coordinate format
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int TRIG_WIDTH  = 18;
   localparam int PROD_WIDTH  = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int SHR_WIDTH   = SUM_WIDTH - FRAC_BITS;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;

   // angle codes and sine table
   localparam int ANGLE_WIDTH = 9;
   localparam int ANGLE_CODES = 2 ** ANGLE_WIDTH;
   localparam int ANGLE_STEPS = 360;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = COORD_WIDTH;

   localparam int NUM_AXES = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POS_X = 3'd0,
      CSR_POS_Y = 3'd1,
      CSR_POS_Z = 3'd2,
      CSR_ROT_X = 3'd3,
      CSR_ROT_Y = 3'd4,
      CSR_ROT_Z = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;

   localparam coord_type COORD_MAX = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } req_payload_type;

   typedef struct packed {
      coord_type out_point_x;
      coord_type out_point_y;
      coord_type out_point_z;
      coord_type out_dir_x;
      coord_type out_dir_y;
      coord_type out_dir_z;
   } rsp_payload_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      vec_type point;
      vec_type dir;
   } ray_vec_type;

   // products of one plane rotation: u' = u*c + w*k1, w' = u*k2 + w*c
   typedef struct packed {
      prod_type  uc;
      prod_type  wk1;
      prod_type  uk2;
      prod_type  wc;
      coord_type keep;
   } pair_prod_type;

   typedef struct packed {
      pair_prod_type point;
      pair_prod_type dir;
   } ray_prod_type;

   typedef struct packed {
      trig_type sin;
      trig_type cos;
   } trig_pair_type;

   typedef struct packed {
      trig_type cos;
      trig_type sin;
      trig_type nsin;
   } axis_trig_type;

   typedef trig_pair_type [ANGLE_CODES-1:0] trig_tab_type;

   // Q2.16 sine of a phase given in quarter turns times ANGLE_STEPS
   function automatic trig_type qsin(longint unsigned m);
      longint unsigned q;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          res;
      q = (m / ANGLE_STEPS) & 64'd3;
      r = m % ANGLE_STEPS;
      if (q[0]) begin
         r = ANGLE_STEPS - r;
      end
      x    = (HALF_PI_Q30 * r + ANGLE_STEPS / 2) / ANGLE_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 0; k < 7; k++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[k];
         if (k % 2 == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      res = (sum + 8192) / 16384;
      if (res > 65536) begin
         res = 65536;
      end
      if (q >= 2) begin
         res = -res;
      end
      return trig_type'(res);
   endfunction

   // sine and cosine for every angle code, wrapped modulo ANGLE_STEPS
   function automatic trig_tab_type trig_build();
      trig_tab_type    t;
      longint unsigned a;
      for (int i = 0; i < ANGLE_CODES; i++) begin
         a         = longint'(i) % ANGLE_STEPS;
         t[i].sin  = qsin(4 * a);
         t[i].cos  = qsin(4 * a + ANGLE_STEPS);
      end
      return t;
   endfunction

   localparam trig_tab_type TRIG_TAB = trig_build();

   // four products of one plane rotation
   function automatic pair_prod_type pair_mul(coord_type u, coord_type w, coord_type keep,
                                              trig_type c, trig_type k1, trig_type k2);
      pair_prod_type p;
      p.uc   = prod_type'(u) * prod_type'(c);
      p.wk1  = prod_type'(w) * prod_type'(k1);
      p.uk2  = prod_type'(u) * prod_type'(k2);
      p.wc   = prod_type'(w) * prod_type'(c);
      p.keep = keep;
      return p;
   endfunction

   // floor((a + b) / 2^16), saturated to the coordinate range
   function automatic coord_type pair_sum(prod_type a, prod_type b);
      sum_type                    s;
      logic [SHR_WIDTH-1:0]       q;
      logic [SHR_WIDTH-COORD_WIDTH:0] top;
      s   = sum_type'(a) + sum_type'(b);
      q   = s[SUM_WIDTH-1:FRAC_BITS];
      top = q[SHR_WIDTH-1:COORD_WIDTH-1];
      if ((&top) || (~|top)) begin
         return coord_type'(q[COORD_WIDTH-1:0]);
      end
      return q[SHR_WIDTH-1] ? COORD_MIN : COORD_MAX;
   endfunction

   // a - b, saturated to the coordinate range
   function automatic coord_type sat_sub(coord_type a, coord_type b);
      diff_type d;
      d = diff_type'(a) - diff_type'(b);
      if (d[DIFF_WIDTH-1] != d[DIFF_WIDTH-2]) begin
         return d[DIFF_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
      return coord_type'(d[COORD_WIDTH-1:0]);
   endfunction

endpackage

// ===== rtl/ray_rotate_translate_unit.sv =====
`timescale 1ns / 1ps
// top level of the ray rotate and translate unit: csr bank, trig lookup and datapath pipeline
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_payload: view point and direction
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_payload: rotated point and direction
//   csr     | in        | csr_we                 | csr_index, csr_wdata
//
// one ray per cycle while rsp_stall is low; a ray passes the input register, then
// a multiply and an add/saturate stage per rotation (X, Y, Z), then the translate stage,
// which is also the output register.
// an angle write reaches the datapath in time for a ray taken in the next cycle.
// synchronous reset empties the pipeline and sets position and angles to zero.
// each stage holds while the one after it is full and stalled, so bubbles fill up.
module ray_rotate_translate_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rrt_pkg::req_payload_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rrt_pkg::rsp_payload_type               rsp_payload,
   input  logic                                   csr_we,
   input  logic [rrt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rrt_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import rrt_pkg::*;

`include "ray_rotate_translate_unit_defines.svh"

   localparam int NUM_STAGES = 8;
   localparam int LAST       = NUM_STAGES - 1;

   // configuration state
   coord_type     pos_ff     [NUM_AXES];
   trig_pair_type half_lo_ff [NUM_AXES];
   trig_pair_type half_hi_ff [NUM_AXES];
   logic          half_sel_ff[NUM_AXES];
   axis_trig_type trig_ff    [NUM_AXES];

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   // pipeline data
   ray_vec_type     st0_ff, st0_in;
   ray_prod_type    st1_ff, st1_in;
   ray_vec_type     st2_ff, st2_in;
   ray_prod_type    st3_ff, st3_in;
   ray_vec_type     st4_ff, st4_in;
   ray_prod_type    st5_ff, st5_in;
   ray_vec_type     st6_ff, st6_in;
   rsp_payload_type st7_ff, st7_in;

   // csr writes; angle writes look up both table halves at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            pos_ff[a]      <= '0;
            half_lo_ff[a]  <= TRIG_TAB[0];
            half_hi_ff[a]  <= TRIG_TAB[0];
            half_sel_ff[a] <= 1'b0;
            trig_ff[a]     <= '{cos: TRIG_TAB[0].cos, sin: TRIG_TAB[0].sin,
                                nsin: trig_type'(-TRIG_TAB[0].sin)};
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POS_X: pos_ff[AXIS_X] <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_POS_Y: pos_ff[AXIS_Y] <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_POS_Z: pos_ff[AXIS_Z] <= coord_type'(csr_wdata[COORD_WIDTH-1:0]);
               CSR_ROT_X: begin
                  half_lo_ff[AXIS_X]  <= TRIG_TAB[{1'b0, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_hi_ff[AXIS_X]  <= TRIG_TAB[{1'b1, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_sel_ff[AXIS_X] <= csr_wdata[ANGLE_WIDTH-1];
               end
               CSR_ROT_Y: begin
                  half_lo_ff[AXIS_Y]  <= TRIG_TAB[{1'b0, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_hi_ff[AXIS_Y]  <= TRIG_TAB[{1'b1, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_sel_ff[AXIS_Y] <= csr_wdata[ANGLE_WIDTH-1];
               end
               CSR_ROT_Z: begin
                  half_lo_ff[AXIS_Z]  <= TRIG_TAB[{1'b0, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_hi_ff[AXIS_Z]  <= TRIG_TAB[{1'b1, csr_wdata[ANGLE_WIDTH-2:0]}];
                  half_sel_ff[AXIS_Z] <= csr_wdata[ANGLE_WIDTH-1];
               end
               default: ;
            endcase
         end
         // pick the table half and form the negated sine
         for (int a = 0; a < NUM_AXES; a++) begin
            if (half_sel_ff[a]) begin
               trig_ff[a] <= '{cos: half_hi_ff[a].cos, sin: half_hi_ff[a].sin,
                               nsin: trig_type'(-half_hi_ff[a].sin)};
            end else begin
               trig_ff[a] <= '{cos: half_lo_ff[a].cos, sin: half_lo_ff[a].sin,
                               nsin: trig_type'(-half_lo_ff[a].sin)};
            end
         end
      end
   end

   // stage enables: a stage loads when it is empty or its content moves on
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign req_stall   = !ready[0];
   assign rsp_valid   = valid_ff[LAST];
   assign rsp_payload = st7_ff;

   // next stage values
   always_comb begin
      // input transfer
      st0_in.point = '{x: req_payload.point_x, y: req_payload.point_y, z: req_payload.point_z};
      st0_in.dir   = '{x: req_payload.dir_x, y: req_payload.dir_y, z: req_payload.dir_z};

      // rotation about X: y' = y*c - z*s, z' = y*s + z*c
      st1_in.point = pair_mul(st0_ff.point.y, st0_ff.point.z, st0_ff.point.x,
                              trig_ff[AXIS_X].cos, trig_ff[AXIS_X].nsin, trig_ff[AXIS_X].sin);
      st1_in.dir   = pair_mul(st0_ff.dir.y, st0_ff.dir.z, st0_ff.dir.x,
                              trig_ff[AXIS_X].cos, trig_ff[AXIS_X].nsin, trig_ff[AXIS_X].sin);
      st2_in.point = '{x: st1_ff.point.keep,
                       y: pair_sum(st1_ff.point.uc, st1_ff.point.wk1),
                       z: pair_sum(st1_ff.point.uk2, st1_ff.point.wc)};
      st2_in.dir   = '{x: st1_ff.dir.keep,
                       y: pair_sum(st1_ff.dir.uc, st1_ff.dir.wk1),
                       z: pair_sum(st1_ff.dir.uk2, st1_ff.dir.wc)};

      // rotation about Y: x' = x*c + z*s, z' = -x*s + z*c
      st3_in.point = pair_mul(st2_ff.point.x, st2_ff.point.z, st2_ff.point.y,
                              trig_ff[AXIS_Y].cos, trig_ff[AXIS_Y].sin, trig_ff[AXIS_Y].nsin);
      st3_in.dir   = pair_mul(st2_ff.dir.x, st2_ff.dir.z, st2_ff.dir.y,
                              trig_ff[AXIS_Y].cos, trig_ff[AXIS_Y].sin, trig_ff[AXIS_Y].nsin);
      st4_in.point = '{x: pair_sum(st3_ff.point.uc, st3_ff.point.wk1),
                       y: st3_ff.point.keep,
                       z: pair_sum(st3_ff.point.uk2, st3_ff.point.wc)};
      st4_in.dir   = '{x: pair_sum(st3_ff.dir.uc, st3_ff.dir.wk1),
                       y: st3_ff.dir.keep,
                       z: pair_sum(st3_ff.dir.uk2, st3_ff.dir.wc)};

      // rotation about Z: x' = x*c - y*s, y' = x*s + y*c
      st5_in.point = pair_mul(st4_ff.point.x, st4_ff.point.y, st4_ff.point.z,
                              trig_ff[AXIS_Z].cos, trig_ff[AXIS_Z].nsin, trig_ff[AXIS_Z].sin);
      st5_in.dir   = pair_mul(st4_ff.dir.x, st4_ff.dir.y, st4_ff.dir.z,
                              trig_ff[AXIS_Z].cos, trig_ff[AXIS_Z].nsin, trig_ff[AXIS_Z].sin);
      st6_in.point = '{x: pair_sum(st5_ff.point.uc, st5_ff.point.wk1),
                       y: pair_sum(st5_ff.point.uk2, st5_ff.point.wc),
                       z: st5_ff.point.keep};
      st6_in.dir   = '{x: pair_sum(st5_ff.dir.uc, st5_ff.dir.wk1),
                       y: pair_sum(st5_ff.dir.uk2, st5_ff.dir.wc),
                       z: st5_ff.dir.keep};

      // translate the view point only
      st7_in.out_point_x = sat_sub(st6_ff.point.x, pos_ff[AXIS_X]);
      st7_in.out_point_y = sat_sub(st6_ff.point.y, pos_ff[AXIS_Y]);
      st7_in.out_point_z = sat_sub(st6_ff.point.z, pos_ff[AXIS_Z]);
      st7_in.out_dir_x   = st6_ff.dir.x;
      st7_in.out_dir_y   = st6_ff.dir.y;
      st7_in.out_dir_z   = st6_ff.dir.z;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         st0_ff <= st0_in;
      end
      if (ready[1]) begin
         st1_ff <= st1_in;
      end
      if (ready[2]) begin
         st2_ff <= st2_in;
      end
      if (ready[3]) begin
         st3_ff <= st3_in;
      end
      if (ready[4]) begin
         st4_ff <= st4_in;
      end
      if (ready[5]) begin
         st5_ff <= st5_in;
      end
      if (ready[6]) begin
         st6_ff <= st6_in;
      end
      if (ready[7]) begin
         st7_ff <= st7_in;
      end
   end

   // checks
   `RRT_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
                    $countones(valid_ff) == NUM_STAGES,
                    "input stalled while the pipeline has a bubble")
   `RRT_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, valid_ff[0],
                    "accepted ray did not enter the first stage")
   `RRT_ASSERT_NEXT(a_drain_empties, clock, reset,
                    rsp_valid && !rsp_stall && !valid_ff[LAST-1], !rsp_valid,
                    "result repeated after its transfer")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench for the ray rotate and translate unit: stimulus, fixed-point predictor and checker
module tb;
   import rrt_pkg::*;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_POS_X;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // predictor copy of the pose registers
   coord_type       pose_x = '0;
   coord_type       pose_y = '0;
   coord_type       pose_z = '0;
   logic [ANGLE_WIDTH-1:0] turn_x = '0;
   logic [ANGLE_WIDTH-1:0] turn_y = '0;
   logic [ANGLE_WIDTH-1:0] turn_z = '0;

   // Q2.16 sine and cosine per whole degree
   longint          sine_q16 [ANGLE_STEPS];
   longint          cosine_q16 [ANGLE_STEPS];

   rsp_payload_type pending_rays [$];
   int              mismatch_count = 0;
   bit              sender_idle_on = 1'b1;
   bit              receiver_idle_on = 1'b1;
   int              hold_off_cycles = 0;

   ray_rotate_translate_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // taylor series sine, phase in quarter turns times ANGLE_STEPS
   function automatic longint taylor_sine(longint unsigned phase);
      longint unsigned quad;
      longint unsigned offs;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      quad = (phase / ANGLE_STEPS) % 4;
      offs = phase % ANGLE_STEPS;
      if (quad == 1 || quad == 3) begin
         offs = ANGLE_STEPS - offs;
      end
      x    = (HALF_PI_Q30 * offs + ANGLE_STEPS / 2) / ANGLE_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 8192) / 16384;
      if (acc > 65536) begin
         acc = 65536;
      end
      return (quad >= 2) ? -acc : acc;
   endfunction

   // floor((a*ka + b*kb) / 2^16), saturated to the coordinate range
   function automatic coord_type plane_mix(coord_type a, longint ka, coord_type b, longint kb);
      longint acc;
      acc = (longint'(a) * ka + longint'(b) * kb) >>> 16;
      if (acc > longint'(COORD_MAX)) begin
         return COORD_MAX;
      end
      if (acc < longint'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return coord_type'(acc);
   endfunction

   // rotation about X, then Y, then Z with the current angles
   function automatic vec_type rotate_vec(vec_type v);
      vec_type   r;
      coord_type t;
      longint    sx;
      longint    cx;
      longint    sy;
      longint    cy;
      longint    sz;
      longint    cz;
      sx = sine_q16[turn_x % ANGLE_STEPS];
      cx = cosine_q16[turn_x % ANGLE_STEPS];
      sy = sine_q16[turn_y % ANGLE_STEPS];
      cy = cosine_q16[turn_y % ANGLE_STEPS];
      sz = sine_q16[turn_z % ANGLE_STEPS];
      cz = cosine_q16[turn_z % ANGLE_STEPS];
      r = v;
      t   = plane_mix(r.y, cx, r.z, -sx);
      r.z = plane_mix(r.y, sx, r.z, cx);
      r.y = t;
      t   = plane_mix(r.x, cy, r.z, sy);
      r.z = plane_mix(r.x, -sy, r.z, cy);
      r.x = t;
      t   = plane_mix(r.x, cz, r.y, -sz);
      r.y = plane_mix(r.x, sz, r.y, cz);
      r.x = t;
      return r;
   endfunction

   // a - b, saturated to the coordinate range
   function automatic coord_type shift_point(coord_type a, coord_type b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > longint'(COORD_MAX)) begin
         return COORD_MAX;
      end
      if (d < longint'(COORD_MIN)) begin
         return COORD_MIN;
      end
      return coord_type'(d);
   endfunction

   // expected result of one ray under the current pose
   function automatic rsp_payload_type transform_ray(req_payload_type ray);
      vec_type         p;
      vec_type         d;
      rsp_payload_type res;
      p.x = ray.point_x;
      p.y = ray.point_y;
      p.z = ray.point_z;
      d.x = ray.dir_x;
      d.y = ray.dir_y;
      d.z = ray.dir_z;
      p = rotate_vec(p);
      d = rotate_vec(d);
      res.out_point_x = shift_point(p.x, pose_x);
      res.out_point_y = shift_point(p.y, pose_y);
      res.out_point_z = shift_point(p.z, pose_z);
      res.out_dir_x   = d.x;
      res.out_dir_y   = d.y;
      res.out_dir_z   = d.z;
      return res;
   endfunction

   function automatic req_payload_type make_ray(coord_type px, coord_type py, coord_type pz,
                                                coord_type dx, coord_type dy, coord_type dz);
      req_payload_type r;
      r.point_x = px;
      r.point_y = py;
      r.point_z = pz;
      r.dir_x   = dx;
      r.dir_y   = dy;
      r.dir_z   = dz;
      return r;
   endfunction

   // mix of extremes, full-range and smaller magnitudes
   function automatic coord_type rand_coord();
      coord_type v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
         1, 2: v = coord_type'($urandom);
         default: begin
            v = coord_type'($urandom);
            v = v >>> $urandom_range(1, 20);
         end
      endcase
      return v;
   endfunction

   function automatic req_payload_type random_ray();
      return make_ray(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
   endfunction

   // angle write data: mostly in range, some wrapped codes, junk in the unused upper bits
   function automatic logic [CSR_DATA_WIDTH-1:0] random_turn();
      logic [CSR_DATA_WIDTH-1:0] v;
      if ($urandom_range(0, 3) == 0) begin
         v = $urandom_range(ANGLE_STEPS, ANGLE_CODES - 1);
      end else begin
         v = $urandom_range(0, ANGLE_STEPS - 1);
      end
      if ($urandom_range(0, 1) == 1) begin
         v[CSR_DATA_WIDTH-1:ANGLE_WIDTH] = (CSR_DATA_WIDTH-ANGLE_WIDTH)'($urandom);
      end
      return v;
   endfunction

   function automatic void check_field(string name, coord_type want, coord_type got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one ray transfer, with an optional gap before it
   task automatic send_ray(input req_payload_type ray);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ray;
      do @(posedge clock); while (req_stall);
      pending_rays.push_back(transform_ray(ray));
   endtask

   // stop sending and wait until every ray has come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_rays.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // write all six pose registers, block idle
   task automatic load_pose(input coord_type px, input coord_type py, input coord_type pz,
                            input logic [CSR_DATA_WIDTH-1:0] ax,
                            input logic [CSR_DATA_WIDTH-1:0] ay,
                            input logic [CSR_DATA_WIDTH-1:0] az);
      logic [CSR_DATA_WIDTH-1:0] vals [6];
      csr_index_type             idx;
      vals = '{px, py, pz, ax, ay, az};
      idx  = CSR_POS_X;
      for (int k = 0; k < 6; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[k];
         @(posedge clock);
         case (idx)
            CSR_POS_X: pose_x = vals[k];
            CSR_POS_Y: pose_y = vals[k];
            CSR_POS_Z: pose_z = vals[k];
            CSR_ROT_X: turn_x = vals[k][ANGLE_WIDTH-1:0];
            CSR_ROT_Y: turn_y = vals[k][ANGLE_WIDTH-1:0];
            CSR_ROT_Z: turn_z = vals[k][ANGLE_WIDTH-1:0];
            default: ;
         endcase
         idx = idx.next();
      end
      csr_we <= 1'b0;
   endtask

   // reset pose: extremes pass straight through
   task automatic test_reset_pose();
      send_ray(make_ray('0, '0, '0, '0, '0, '0));
      send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_ray(make_ray(32'sh0001_0000, -32'sh0001_0000, '1, -32'sh0001_0000, 32'sh0001_0000,
                        32'sh0000_8000));
      send_ray(make_ray(COORD_MAX, COORD_MIN, '1, COORD_MIN, COORD_MAX, '0));
      settle_pipeline();
   endtask

   // quarter turns per axis, diagonal saturation, wrapped codes, translation overflow
   task automatic test_angle_cases();
      coord_type                 px [6];
      coord_type                 py [6];
      logic [CSR_DATA_WIDTH-1:0] ax [6];
      logic [CSR_DATA_WIDTH-1:0] ay [6];
      logic [CSR_DATA_WIDTH-1:0] az [6];
      px = '{'0, 32'sh0003_0000, '0, COORD_MAX, COORD_MIN, COORD_MIN};
      py = '{'0, '0, -32'sh0002_8000, COORD_MIN, COORD_MAX, COORD_MAX};
      ax = '{90, 0, 0, 45, 180, ANGLE_STEPS};
      ay = '{0, 90, 0, 45, 270, ANGLE_CODES - 1};
      az = '{0, 0, 90, 45, 30, ANGLE_STEPS - 1};
      for (int i = 0; i < 6; i++) begin
         load_pose(px[i], py[i], px[i], ax[i], ay[i], az[i]);
         send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
         send_ray(make_ray(COORD_MIN, COORD_MAX, COORD_MAX, 32'sh0001_0000, '0, '0));
         send_ray(random_ray());
         settle_pipeline();
      end
   endtask

   // random poses, random rays, both sides idling
   task automatic test_random_poses();
      for (int phase = 0; phase < 8; phase++) begin
         load_pose(rand_coord(), rand_coord(), rand_coord(),
                   random_turn(), random_turn(), random_turn());
         repeat (160) send_ray(random_ray());
         settle_pipeline();
      end
   endtask

   // receiver holds off for a long stretch while rays keep coming
   task automatic test_backpressure();
      load_pose(rand_coord(), rand_coord(), rand_coord(),
                random_turn(), random_turn(), random_turn());
      sender_idle_on  = 1'b0;
      hold_off_cycles = 200;
      repeat (120) send_ray(random_ray());
      settle_pipeline();
      sender_idle_on = 1'b1;
   endtask

   // full rate, no idling on either side
   task automatic test_streaming();
      load_pose(rand_coord(), rand_coord(), rand_coord(),
                random_turn(), random_turn(), random_turn());
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      repeat (300) send_ray(random_ray());
      settle_pipeline();
   endtask

   // receiver pacing: long hold-off first, then random stall bursts
   initial begin : rsp_pacing
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 15) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest pending ray
   always @(posedge clock) begin : ray_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rays.size() == 0) begin
            $error("rsp transfer with no ray pending");
            mismatch_count++;
         end else begin
            want = pending_rays.pop_front();
            check_field("out_point_x", want.out_point_x, rsp_payload.out_point_x);
            check_field("out_point_y", want.out_point_y, rsp_payload.out_point_y);
            check_field("out_point_z", want.out_point_z, rsp_payload.out_point_z);
            check_field("out_dir_x", want.out_dir_x, rsp_payload.out_dir_x);
            check_field("out_dir_y", want.out_dir_y, rsp_payload.out_dir_y);
            check_field("out_dir_z", want.out_dir_z, rsp_payload.out_dir_z);
         end
      end
   end

   initial begin
      for (int a = 0; a < ANGLE_STEPS; a++) begin
         sine_q16[a]   = taylor_sine(4 * a);
         cosine_q16[a] = taylor_sine(4 * a + ANGLE_STEPS);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_pose();
      test_angle_cases();
      test_random_poses();
      test_backpressure();
      test_streaming();
      if (mismatch_count == 0 && pending_rays.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
